// ----- rtl/core/slot_allocator_with_wait_queue_macros.svh -----
// assertion helpers shared by the allocator rtl
// all of them sample on clk and stay quiet while arst_n is low
`ifndef SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must never be seen
`define SA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/core/sa_pkg.sv -----
`default_nettype none

package sa_pkg;

	// defaults for the top level parameters
	localparam int DEF_MAX_SLOTS   = 16;
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_ID_BITS     = 16;

	// fixed field widths
	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 4;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 5'd16;

	// command codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_ARRIVE  = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_LIST_Q  = 2'd2,
		ACT_LIST_S  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_PLACED  = 4'd0,
		STS_QUEUED  = 4'd1,
		STS_DROPPED = 4'd2,
		STS_FREED   = 4'd3,
		STS_REFILL  = 4'd4,
		STS_BAD     = 4'd5,
		STS_QENTRY  = 4'd6,
		STS_QEMPTY  = 4'd7,
		STS_SENTRY  = 4'd8
	} status_t;

	// requests from the sequencer to the wait queue
	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} q_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sa_wait_queue.sv -----
`default_nettype none

`include "slot_allocator_with_wait_queue_macros.svh"

module sa_wait_queue #(
	parameter int QUEUE_DEPTH = sa_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = sa_pkg::DEF_ID_BITS,
	localparam int QAW = $clog2(QUEUE_DEPTH),
	localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sa_pkg::q_ctrl_t   ctrl,
	input  wire logic [ID_BITS-1:0] push_id,
	input  wire logic [QAW-1:0]    rd_ofs,
	output logic      [ID_BITS-1:0] rd_data,
	output logic      [QCW-1:0]    count
);

	localparam logic [QAW:0] DEPTH_W = (QAW+1)'(QUEUE_DEPTH);

	logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
	logic [QAW-1:0]     head_q;
	logic [QCW-1:0]     count_q;
	logic [QAW:0]       rd_sum;
	logic [QAW:0]       wr_sum;
	logic [QAW-1:0]     rd_addr;
	logic [QAW-1:0]     wr_addr;

	// circular addresses, sums stay below twice the depth
	always_comb begin
		rd_sum  = {1'b0, head_q} + {1'b0, rd_ofs};
		wr_sum  = {1'b0, head_q} + (QAW+1)'(count_q);
		rd_addr = (rd_sum >= DEPTH_W) ? QAW'(rd_sum - DEPTH_W) : QAW'(rd_sum);
		wr_addr = (wr_sum >= DEPTH_W) ? QAW'(wr_sum - DEPTH_W) : QAW'(wr_sum);
	end

	// head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q  <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (ctrl.push) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// entry storage with registered read
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_addr] <= push_id;
		end
		if (ctrl.rd) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign count = count_q;

	`SA_ASSERT_NEVER(a_push_full, ctrl.push && (count_q == QCW'(QUEUE_DEPTH)), "push into full queue")
	`SA_ASSERT_NEVER(a_pop_empty, ctrl.pop && (count_q == '0), "pop from empty queue")
	`SA_ASSERT_IMPL(a_head_range, 1'b1, {1'b0, head_q} < DEPTH_W, "queue head out of range")

endmodule

`default_nettype wire

// ----- rtl/core/slot_allocator_with_wait_queue.sv -----
`default_nettype none

// channel    | signals                                         | dir | handshake
// -----------+-------------------------------------------------+-----+------------------------
// command    | action, requester_id, slot_number               | in  | start && !busy
// config     | cfg_data                                        | in  | cfg_valid && cfg_ready
// result     | status, slot_out, id_out, occupied, last        | out | result_strobe, 1 cycle
//
// arrive scans one slot per cycle until a free slot or the last slot, result in the cycle after
// release reads owner/queue in the accept cycle, decides in S_REL, then registers the result;
// bad slot is answered from idle; listings stream one result per cycle after the first read;
// queue empty is answered from idle; the single incrementer/compare and read ports set these rates
// reset clears slot busy bits and queue head/count, sets slot_count to 16; stores are not cleared
// results cannot be stalled; busy drops in the cycle the last result of a command is shown

`include "slot_allocator_with_wait_queue_macros.svh"

module slot_allocator_with_wait_queue #(
	parameter int MAX_SLOTS   = sa_pkg::DEF_MAX_SLOTS,
	parameter int QUEUE_DEPTH = sa_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = sa_pkg::DEF_ID_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [sa_pkg::ACTION_W-1:0] action,
	input  wire logic [ID_BITS-1:0]          requester_id,
	input  wire logic [sa_pkg::SLOT_W-1:0]   slot_number,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sa_pkg::SLOT_W-1:0]   cfg_data,
	output logic                             result_strobe,
	output logic      [sa_pkg::STATUS_W-1:0] status,
	output logic      [sa_pkg::SLOT_W-1:0]   slot_out,
	output logic      [ID_BITS-1:0]          id_out,
	output logic                             occupied,
	output logic                             last
);

	localparam int SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW  = (SCW > QCW) ? SCW : QCW;
	localparam int SW  = sa_pkg::SLOT_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_REL   = 5'b00100,
		S_QLIST = 5'b01000,
		S_SLIST = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [SW-1:0]        slot_count_q;
	logic [SCW-1:0]       n_now;
	logic [SCW-1:0]       n_q;
	logic [ID_BITS-1:0]   id_q;
	logic [SW-1:0]        sn_q;
	logic [IW-1:0]        idx_q, idx_d, idx_nxt, lim;
	logic                 at_last;
	logic [SAW-1:0]       idx_slot, sn_idx;
	logic                 accept, bad_sn;

	logic [MAX_SLOTS-1:0] busy_bits_q;
	logic                 bset, bclr;
	logic [SAW-1:0]       baddr;

	logic [ID_BITS-1:0]   owner_mem [MAX_SLOTS];
	logic [ID_BITS-1:0]   owner_rd_q;
	logic                 owner_re, owner_we;
	logic [SAW-1:0]       owner_raddr, owner_waddr;
	logic [ID_BITS-1:0]   owner_wdata;

	sa_pkg::q_ctrl_t      q_ctrl;
	logic [QAW-1:0]       q_ofs;
	logic [ID_BITS-1:0]   q_rd;
	logic [QCW-1:0]       q_count;

	logic                        emit;
	logic [sa_pkg::STATUS_W-1:0] r_status;
	logic [SW-1:0]               r_slot;
	logic [ID_BITS-1:0]          r_id;
	logic                        r_occ, r_last;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = start && !busy;

	// active slot count, clamped to 1..MAX_SLOTS
	always_comb begin
		if (slot_count_q == '0) begin
			n_now = SCW'(1);
		end else if (8'(slot_count_q) > 8'(MAX_SLOTS)) begin
			n_now = SCW'(MAX_SLOTS);
		end else begin
			n_now = SCW'(slot_count_q);
		end
	end

	assign bad_sn = (slot_number == '0) || (8'(slot_number) > 8'(n_now));

	// shared step counter: one incrementer and one end compare
	assign idx_nxt  = idx_q + 1'b1;
	assign lim      = (state_q == S_QLIST) ? IW'(q_count) : IW'(n_q);
	assign at_last  = (idx_nxt == lim);
	assign idx_slot = idx_q[SAW-1:0];
	assign sn_idx   = SAW'(sn_q - 5'd1);

	// sequencer
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		emit        = 1'b0;
		r_status    = sa_pkg::STS_PLACED;
		r_slot      = '0;
		r_id        = '0;
		r_occ       = 1'b0;
		r_last      = 1'b1;
		owner_re    = 1'b0;
		owner_raddr = idx_slot;
		owner_we    = 1'b0;
		owner_waddr = idx_slot;
		owner_wdata = id_q;
		bset        = 1'b0;
		bclr        = 1'b0;
		baddr       = idx_slot;
		q_ctrl      = '0;
		q_ofs       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d = '0;
					case (action)
						sa_pkg::ACT_ARRIVE: begin
							state_d = S_SCAN;
						end
						sa_pkg::ACT_RELEASE: begin
							if (bad_sn) begin
								emit     = 1'b1;
								r_status = sa_pkg::STS_BAD;
								r_slot   = slot_number;
							end else begin
								owner_re    = 1'b1;
								owner_raddr = SAW'(slot_number - 5'd1);
								q_ctrl.rd   = 1'b1;
								state_d     = S_REL;
							end
						end
						sa_pkg::ACT_LIST_Q: begin
							if (q_count == '0) begin
								emit     = 1'b1;
								r_status = sa_pkg::STS_QEMPTY;
							end else begin
								q_ctrl.rd = 1'b1;
								state_d   = S_QLIST;
							end
						end
						sa_pkg::ACT_LIST_S: begin
							owner_re    = 1'b1;
							owner_raddr = '0;
							state_d     = S_SLIST;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!busy_bits_q[idx_slot]) begin
					owner_we = 1'b1;
					bset     = 1'b1;
					emit     = 1'b1;
					r_status = sa_pkg::STS_PLACED;
					r_slot   = SW'(idx_nxt);
					r_id     = id_q;
					r_occ    = 1'b1;
					state_d  = S_IDLE;
				end else if (at_last) begin
					emit = 1'b1;
					r_id = id_q;
					if (q_count != QCW'(QUEUE_DEPTH)) begin
						q_ctrl.push = 1'b1;
						r_status    = sa_pkg::STS_QUEUED;
					end else begin
						r_status = sa_pkg::STS_DROPPED;
					end
					state_d = S_IDLE;
				end else begin
					idx_d = idx_nxt;
				end
			end
			S_REL: begin
				baddr       = sn_idx;
				owner_waddr = sn_idx;
				emit        = 1'b1;
				r_slot      = sn_q;
				if (q_count != '0) begin
					q_ctrl.pop  = 1'b1;
					owner_we    = 1'b1;
					owner_wdata = q_rd;
					bset        = 1'b1;
					r_status    = sa_pkg::STS_REFILL;
					r_id        = q_rd;
					r_occ       = 1'b1;
				end else begin
					bclr     = 1'b1;
					r_status = sa_pkg::STS_FREED;
					r_id     = busy_bits_q[sn_idx] ? owner_rd_q : '0;
				end
				state_d = S_IDLE;
			end
			S_QLIST: begin
				emit     = 1'b1;
				r_status = sa_pkg::STS_QENTRY;
				r_id     = q_rd;
				r_last   = at_last;
				if (at_last) begin
					state_d = S_IDLE;
				end else begin
					idx_d     = idx_nxt;
					q_ctrl.rd = 1'b1;
					q_ofs     = QAW'(idx_nxt);
				end
			end
			S_SLIST: begin
				emit     = 1'b1;
				r_status = sa_pkg::STS_SENTRY;
				r_slot   = SW'(idx_nxt);
				r_occ    = busy_bits_q[idx_slot];
				r_id     = busy_bits_q[idx_slot] ? owner_rd_q : '0;
				r_last   = at_last;
				if (at_last) begin
					state_d = S_IDLE;
				end else begin
					idx_d       = idx_nxt;
					owner_re    = 1'b1;
					owner_raddr = SAW'(idx_nxt);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slot_count_q  <= sa_pkg::SLOT_COUNT_RESET;
			busy_bits_q   <= '0;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			result_strobe <= emit;
			if (cfg_valid && cfg_ready) begin
				slot_count_q <= cfg_data;
			end
			if (bset) begin
				busy_bits_q[baddr] <= 1'b1;
			end else if (bclr) begin
				busy_bits_q[baddr] <= 1'b0;
			end
		end
	end

	// command transaction capture, step counter and result register
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			id_q <= requester_id;
			sn_q <= slot_number;
			n_q  <= n_now;
		end
		if (emit) begin
			status   <= r_status;
			slot_out <= r_slot;
			id_out   <= r_id;
			occupied <= r_occ;
			last     <= r_last;
		end
	end

	// slot owner store with registered read
	always_ff @(posedge clk) begin
		if (owner_we) begin
			owner_mem[owner_waddr] <= owner_wdata;
		end
		if (owner_re) begin
			owner_rd_q <= owner_mem[owner_raddr];
		end
	end

	sa_wait_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (q_ctrl),
		.push_id (id_q),
		.rd_ofs  (q_ofs),
		.rd_data (q_rd),
		.count   (q_count)
	);

	`SA_ASSERT_IMPL(a_last_frees, result_strobe && last, !busy, "busy while final result shown")
	`SA_ASSERT_IMPL(a_mid_busy, result_strobe && !last, busy, "non-final result while idle")
	`SA_ASSERT_NEXT(a_stream_gapless, result_strobe && !last, result_strobe, "gap in listing")
	`SA_ASSERT_IMPL(a_scan_range, state_q == S_SCAN, idx_q < IW'(n_q), "slot scan past count")

endmodule

`default_nettype wire

// ----- verif/slot_allocator_with_wait_queue_tb.sv -----
`timescale 1ns / 100ps

module slot_allocator_with_wait_queue_tb;
	import sa_pkg::*;

	localparam int NSLOTS = DEF_MAX_SLOTS;
	localparam int QDEPTH = DEF_QUEUE_DEPTH;
	localparam int ID_W   = DEF_ID_BITS;

	// kinds of entries in the driver backlog
	typedef enum logic [1:0] {
		DO_CMD,
		DO_CFG,
		DO_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		action_t           act;
		logic [ID_W-1:0]   rid;
		logic [SLOT_W-1:0] sn;
		logic [SLOT_W-1:0] cfg;
		int                gap;
	} step_t;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   rid;
		logic              occ;
		logic              lst;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ACTION_W-1:0] action = '0;
	logic [ID_W-1:0] requester_id = '0;
	logic [SLOT_W-1:0] slot_number = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SLOT_W-1:0] cfg_data = '0;
	logic result_strobe;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot_out;
	logic [ID_W-1:0] id_out;
	logic occupied;
	logic last;

	// predictor state
	logic [SLOT_W-1:0] slot_limit = SLOT_COUNT_RESET;
	logic [ID_W-1:0] owner_of [NSLOTS];
	bit taken [NSLOTS] = '{default: 1'b0};
	logic [ID_W-1:0] waiting_ids [$];

	step_t cmd_backlog [$];
	outcome_t owed_results [$];
	step_t nxt;
	outcome_t got;

	int gap_count = 0;
	int quiet_count = 0;
	int mismatches = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int cfg_writes = 0;
	int drops_seen = 0;
	int refills_seen = 0;
	int bad_seen = 0;

	slot_allocator_with_wait_queue DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.requester_id (requester_id),
		.slot_number  (slot_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_strobe(result_strobe),
		.status       (status),
		.slot_out     (slot_out),
		.id_out       (id_out),
		.occupied     (occupied),
		.last         (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// effective slot count: zero acts as one, above the maximum clamps
	function automatic int slots_in_use();
		if (slot_limit < 1) return 1;
		if (slot_limit > NSLOTS) return NSLOTS;
		return int'(slot_limit);
	endfunction

	function automatic void owe(status_t st, int slot, logic [ID_W-1:0] rid, bit occ, bit lst);
		outcome_t r;
		r.status = st;
		r.slot = slot[SLOT_W-1:0];
		r.rid = rid;
		r.occ = occ;
		r.lst = lst;
		owed_results.insert(owed_results.size(), r);
	endfunction

	// update slot/queue state for one accepted command and queue what it reports
	function automatic void apply_command(action_t act, logic [ID_W-1:0] rid,
			logic [SLOT_W-1:0] sn);
		int n;
		int hit;
		int i;
		int idx;
		logic [ID_W-1:0] nid;
		n = slots_in_use();
		hit = -1;
		case (act)
			ACT_ARRIVE: begin
				for (i = 0; i < n; i++)
					if (!taken[i] && hit < 0) hit = i;
				if (hit >= 0) begin
					taken[hit] = 1'b1;
					owner_of[hit] = rid;
					owe(STS_PLACED, hit + 1, rid, 1'b1, 1'b1);
				end else if (waiting_ids.size() < QDEPTH) begin
					waiting_ids.insert(waiting_ids.size(), rid);
					owe(STS_QUEUED, 0, rid, 1'b0, 1'b1);
				end else begin
					owe(STS_DROPPED, 0, rid, 1'b0, 1'b1);
				end
			end
			ACT_RELEASE: begin
				idx = int'(sn) - 1;
				if (sn < 1 || sn > n) begin
					owe(STS_BAD, int'(sn), '0, 1'b0, 1'b1);
				end else if (waiting_ids.size() > 0) begin
					nid = waiting_ids[0];
					waiting_ids.delete(0);
					owner_of[idx] = nid;
					taken[idx] = 1'b1;
					owe(STS_REFILL, int'(sn), nid, 1'b1, 1'b1);
				end else begin
					owe(STS_FREED, int'(sn), taken[idx] ? owner_of[idx] : '0, 1'b0, 1'b1);
					taken[idx] = 1'b0;
				end
			end
			ACT_LIST_Q: begin
				if (waiting_ids.size() == 0)
					owe(STS_QEMPTY, 0, '0, 1'b0, 1'b1);
				for (i = 0; i < waiting_ids.size(); i++)
					owe(STS_QENTRY, 0, waiting_ids[i], 1'b0, i == waiting_ids.size() - 1);
			end
			default: begin
				for (i = 0; i < n; i++)
					owe(STS_SENTRY, i + 1, taken[i] ? owner_of[i] : '0, taken[i], i == n - 1);
			end
		endcase
	endfunction

	// idle cycles before a command: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_cmd(action_t act, logic [ID_W-1:0] rid, logic [SLOT_W-1:0] sn,
			int gap);
		step_t s;
		s.kind = DO_CMD;
		s.act = act;
		s.rid = rid;
		s.sn = sn;
		s.cfg = '0;
		s.gap = gap;
		cmd_backlog.insert(cmd_backlog.size(), s);
	endfunction

	function automatic void queue_ctl(step_kind_t kind, logic [SLOT_W-1:0] value);
		step_t s;
		s.kind = kind;
		s.act = ACT_ARRIVE;
		s.rid = '0;
		s.sn = '0;
		s.cfg = value;
		s.gap = 0;
		cmd_backlog.insert(cmd_backlog.size(), s);
	endfunction

	// driver: commands and slot count writes from the backlog
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			gap_count <= 0;
			quiet_count <= 0;
		end else begin
			if (start && !busy) begin
				apply_command(action_t'(action), requester_id, slot_number);
				cmds_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				slot_limit = cfg_data;
				cfg_writes++;
			end
			if (owed_results.size() == 0 && !busy)
				quiet_count <= quiet_count + 1;
			else
				quiet_count <= 0;

			// a transaction still waiting keeps its signals as they are
			if (!((start && busy) || (cfg_valid && !cfg_ready))) begin
				if (cmd_backlog.size() == 0) begin
					start <= 1'b0;
					cfg_valid <= 1'b0;
				end else begin
					nxt = cmd_backlog[0];
					case (nxt.kind)
						DO_CMD: begin
							cfg_valid <= 1'b0;
							if (gap_count < nxt.gap) begin
								start <= 1'b0;
								gap_count <= gap_count + 1;
							end else begin
								action <= nxt.act;
								requester_id <= nxt.rid;
								slot_number <= nxt.sn;
								start <= 1'b1;
								gap_count <= 0;
								cmd_backlog.delete(0);
							end
						end
						DO_CFG: begin
							start <= 1'b0;
							// write only once the block has gone quiet
							if (quiet_count >= 4 && owed_results.size() == 0 && !busy) begin
								cfg_data <= nxt.cfg;
								cfg_valid <= 1'b1;
								cmd_backlog.delete(0);
							end else begin
								cfg_valid <= 1'b0;
							end
						end
						default: begin
							start <= 1'b0;
							cfg_valid <= 1'b0;
							if (owed_results.size() == 0 && !busy)
								cmd_backlog.delete(0);
						end
					endcase
				end
			end
		end
	end

	// monitor: check each result against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (owed_results.size() == 0) begin
				$error("result with none outstanding: status %0d slot %0d id %0h",
					status, slot_out, id_out);
				mismatches++;
			end else begin
				got = owed_results[0];
				owed_results.delete(0);
				results_checked++;
				if (status !== got.status) begin
					$error("status expected %0d got %0d", got.status, status);
					mismatches++;
				end
				if (slot_out !== got.slot) begin
					$error("slot_out expected %0d got %0d", got.slot, slot_out);
					mismatches++;
				end
				if (id_out !== got.rid) begin
					$error("id_out expected %0h got %0h", got.rid, id_out);
					mismatches++;
				end
				if (occupied !== got.occ) begin
					$error("occupied expected %0b got %0b", got.occ, occupied);
					mismatches++;
				end
				if (last !== got.lst) begin
					$error("last expected %0b got %0b", got.lst, last);
					mismatches++;
				end
				if (got.status == STS_DROPPED) drops_seen++;
				if (got.status == STS_REFILL) refills_seen++;
				if (got.status == STS_BAD) bad_seen++;
			end
		end
	end

	// stimulus and end of run
	initial begin
		int phase_cfg [7];
		int phase_len [7];
		int arr_pct [7];
		int rel_pct [7];
		bit burst [7];
		int p;
		int k;
		int pick;
		int n_eff;
		action_t act;
		logic [SLOT_W-1:0] sn;

		phase_cfg = '{0, 31, 16, 1, 5, 17, 3};
		phase_len = '{40, 25, 25, 15, 25, 15, 15};
		arr_pct = '{90, 20, 55, 50, 50, 40, 45};
		rel_pct = '{5, 70, 35, 40, 40, 40, 40};
		burst = '{0, 0, 1, 0, 0, 1, 0};

		// directed: empty listings, two slots filled, queue use, bad releases, refills
		queue_cmd(ACT_LIST_Q, 16'h0000, 5'd0, 0);
		queue_cmd(ACT_LIST_S, 16'h0000, 5'd0, pick_gap());
		queue_ctl(DO_CFG, 5'd2);
		queue_cmd(ACT_ARRIVE, 16'hFFFF, 5'd0, 0);
		queue_cmd(ACT_ARRIVE, 16'h0000, 5'd31, pick_gap());
		queue_cmd(ACT_ARRIVE, 16'h1234, 5'd0, 0);
		queue_cmd(ACT_ARRIVE, 16'hABCD, 5'd0, pick_gap());
		queue_cmd(ACT_LIST_Q, 16'hFFFF, 5'd31, 0);
		queue_cmd(ACT_LIST_S, 16'h0000, 5'd0, pick_gap());
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd0, 0);
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd3, 0);
		queue_cmd(ACT_RELEASE, 16'hFFFF, 5'd31, pick_gap());
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd1, 0);
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd2, pick_gap());
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd2, 0);
		queue_cmd(ACT_RELEASE, 16'h0000, 5'd2, 0);
		queue_cmd(ACT_ARRIVE, 16'h5A5A, 5'd0, pick_gap());
		queue_cmd(ACT_LIST_S, 16'h0000, 5'd0, 0);

		// random phases, each under its own slot count
		for (p = 0; p < 7; p++) begin
			queue_ctl(DO_CFG, phase_cfg[p][SLOT_W-1:0]);
			n_eff = (phase_cfg[p] < 1) ? 1 : (phase_cfg[p] > NSLOTS) ? NSLOTS : phase_cfg[p];
			for (k = 0; k < phase_len[p]; k++) begin
				if (p == 4 && k == phase_len[p] / 2)
					queue_ctl(DO_DRAIN, '0);
				pick = $urandom_range(0, 99);
				if (pick < arr_pct[p])
					act = ACT_ARRIVE;
				else if (pick < arr_pct[p] + rel_pct[p])
					act = ACT_RELEASE;
				else if (pick[0])
					act = ACT_LIST_Q;
				else
					act = ACT_LIST_S;
				if ($urandom_range(0, 99) < 85)
					sn = SLOT_W'($urandom_range(1, n_eff));
				else
					sn = SLOT_W'($urandom_range(0, 31));
				queue_cmd(act, ID_W'($urandom_range(0, 65535)), sn,
					burst[p] ? 0 : pick_gap());
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || start || cfg_valid || busy
				|| owed_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d commands, %0d results checked, %0d slot count writes",
			cmds_accepted, results_checked, cfg_writes);
		$display("queue overflow drops %0d, refills on release %0d, bad slot releases %0d",
			drops_seen, refills_seen, bad_seen);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(4_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
